// ===== rtl/ohlc_pkg.sv =====
package ohlc_pkg;

    localparam int PRICE_W = 32;
    localparam int TVOL_W  = 24;
    localparam int VOL_W   = 40;
    localparam int WGT_W   = 63;
    localparam int WVOL_W  = 44;
    localparam int PROD_W  = PRICE_W + TVOL_W;

    localparam logic CMD_TRADE = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    localparam logic [VOL_W-1:0]  VOL_MAX  = {VOL_W{1'b1}};
    localparam logic [WGT_W-1:0]  WGT_MAX  = {WGT_W{1'b1}};
    localparam logic [WVOL_W-1:0] WVOL_MAX = {WVOL_W{1'b1}};

    // one trade or close request
    typedef struct packed {
        logic              cmd;
        logic [1:0]        symbol_index;
        logic [PRICE_W-1:0] trade_price;
        logic [TVOL_W-1:0]  trade_volume;
    } in_item_t;

    // one finished candle with window statistics
    typedef struct packed {
        logic [1:0]         out_symbol;
        logic [PRICE_W-1:0] candle_open;
        logic [PRICE_W-1:0] candle_high;
        logic [PRICE_W-1:0] candle_low;
        logic [PRICE_W-1:0] candle_close;
        logic [VOL_W-1:0]   candle_volume;
        logic               carried_forward;
        logic [PRICE_W-1:0] window_vwap;
        logic [WVOL_W-1:0]  window_volume;
    } out_item_t;

    // stored window entry
    typedef struct packed {
        logic [PRICE_W-1:0] open_p;
        logic [PRICE_W-1:0] high_p;
        logic [PRICE_W-1:0] low_p;
        logic [PRICE_W-1:0] close_p;
        logic [VOL_W-1:0]   vol;
        logic [WGT_W-1:0]   wgt;
    } candle_t;

endpackage

// ===== rtl/ohlc_front.sv =====
module ohlc_front #(
    parameter int SYMBOLS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ohlc_pkg::in_item_t req,
    output logic               q_valid,
    input  logic               q_stall,
    output ohlc_pkg::in_item_t q_item
);

    ohlc_pkg::in_item_t fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    // drop items for symbols that do not exist
    assign req_stall = (cnt_reg == 2'd2);
    assign push      = req_valid && !req_stall && (32'(req.symbol_index) < SYMBOLS);
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && !q_stall;
    assign q_item    = fifo_reg[rd_ptr_reg];

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= req;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("queue lost an item");

endmodule

// ===== rtl/ohlc_back.sv =====
module ohlc_back #(
    parameter int SYMBOLS      = 4,
    parameter int WINDOW_DEPTH = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_stall,
    input  ohlc_pkg::in_item_t  q_item,
    output logic                candle_valid,
    input  logic                candle_stall,
    output ohlc_pkg::out_item_t candle
);

    localparam int SW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int HW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int DEPTH  = SYMBOLS * WINDOW_DEPTH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ohlc_pkg::WGT_W + CW;
    localparam int SVOL_W = ohlc_pkg::VOL_W + CW;
    localparam int R_W    = SVOL_W + 1;
    localparam int DW     = $clog2(SUM_W + 1);
    localparam int XW     = SVOL_W + ohlc_pkg::WVOL_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_UPD   = 4'd2;
    localparam logic [3:0] ST_CLOSE = 4'd3;
    localparam logic [3:0] ST_LAST  = 4'd4;
    localparam logic [3:0] ST_WR    = 4'd5;
    localparam logic [3:0] ST_SRD   = 4'd6;
    localparam logic [3:0] ST_SACC  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    ohlc_pkg::in_item_t item_reg;
    logic [SW-1:0]      sym_reg;

    // trade update operands
    logic [SW-1:0]                 upd_sym_reg;
    logic [ohlc_pkg::PRICE_W-1:0]  upd_price_reg;
    logic [ohlc_pkg::TVOL_W-1:0]   upd_vol_reg;
    logic [ohlc_pkg::PROD_W-1:0]   prod_reg;

    // per-symbol accumulators
    logic [ohlc_pkg::PRICE_W-1:0] open_reg  [SYMBOLS];
    logic [ohlc_pkg::PRICE_W-1:0] high_reg  [SYMBOLS];
    logic [ohlc_pkg::PRICE_W-1:0] low_reg   [SYMBOLS];
    logic [ohlc_pkg::PRICE_W-1:0] close_reg [SYMBOLS];
    logic [ohlc_pkg::VOL_W-1:0]   vol_reg   [SYMBOLS];
    logic [ohlc_pkg::WGT_W-1:0]   wgt_reg   [SYMBOLS];
    logic [HW-1:0]                head_reg  [SYMBOLS];
    logic [CW-1:0]                cnt_reg   [SYMBOLS];

    // window ring, all symbols
    ohlc_pkg::candle_t hist_mem [DEPTH];
    ohlc_pkg::candle_t rd_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;

    ohlc_pkg::candle_t candle_reg;
    logic              carried_reg;
    logic [CW-1:0]     k_reg;
    logic [SUM_W-1:0]  wsum_reg;
    logic [SVOL_W-1:0] wvol_reg;
    logic [R_W-1:0]    rem_reg;
    logic [ohlc_pkg::PRICE_W-1:0] quo_reg;
    logic              over_reg;
    logic [DW-1:0]     dcnt_reg;

    logic                out_valid_reg;
    ohlc_pkg::out_item_t out_item_reg;

    logic                q_take;
    logic                out_load;
    logic [AW-1:0]       base;
    logic [HW-1:0]       last_slot;
    logic [HW-1:0]       head_cur;
    logic [CW-1:0]       cnt_cur;
    logic                first_trade;
    logic [ohlc_pkg::VOL_W:0] vsum;
    logic [ohlc_pkg::WGT_W:0] wgsum;
    logic [R_W-1:0]      r_shift;
    logic                r_ge;
    ohlc_pkg::out_item_t out_build;

    assign q_stall      = !((state_reg == ST_IDLE) || (state_reg == ST_UPD));
    assign q_take       = q_valid && !q_stall;
    assign candle_valid = out_valid_reg;
    assign candle       = out_item_reg;
    assign out_load     = (state_reg == ST_OUT) && (!out_valid_reg || !candle_stall);

    assign base      = AW'(sym_reg) * AW'(WINDOW_DEPTH);
    assign head_cur  = head_reg[sym_reg];
    assign cnt_cur   = cnt_reg[sym_reg];
    assign last_slot = (head_cur == HW'(0)) ? HW'(WINDOW_DEPTH - 1) : head_cur - HW'(1);

    // trade arithmetic
    assign first_trade = (vol_reg[upd_sym_reg] == '0);
    assign vsum  = {1'b0, vol_reg[upd_sym_reg]} + (ohlc_pkg::VOL_W + 1)'(upd_vol_reg);
    assign wgsum = {1'b0, wgt_reg[upd_sym_reg]} + (ohlc_pkg::WGT_W + 1)'(prod_reg);

    // one restoring division step
    assign r_shift = {rem_reg[R_W-2:0], wsum_reg[SUM_W-1]};
    assign r_ge    = (r_shift >= {1'b0, wvol_reg});

    // result item
    always_comb
    begin
        out_build.out_symbol      = 2'(sym_reg);
        out_build.candle_open     = candle_reg.open_p;
        out_build.candle_high     = candle_reg.high_p;
        out_build.candle_low      = candle_reg.low_p;
        out_build.candle_close    = candle_reg.close_p;
        out_build.candle_volume   = candle_reg.vol;
        out_build.carried_forward = carried_reg;
        out_build.window_vwap     = over_reg ? '1 : quo_reg;
        out_build.window_volume   = (XW'(wvol_reg) > XW'(ohlc_pkg::WVOL_MAX)) ?
                                    ohlc_pkg::WVOL_MAX : ohlc_pkg::WVOL_W'(wvol_reg);
    end

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = base + AW'(last_slot);
        wr_en   = (state_reg == ST_WR);
        wr_addr = base + AW'(head_cur);
        case (state_reg)
            ST_CLOSE:
            begin
                rd_en = (cnt_cur != '0) && (vol_reg[sym_reg] == '0);
            end
            ST_SRD:
            begin
                rd_en   = (k_reg != cnt_cur);
                rd_addr = base + AW'(k_reg[HW-1:0]);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= candle_reg;
        end
        if (rd_en)
        begin
            rd_reg <= hist_mem[rd_addr];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_UPD:
            begin
                if (q_take)
                begin
                    state_next = (q_item.cmd == ohlc_pkg::CMD_CLOSE) ? ST_CLOSE : ST_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:   state_next = ST_UPD;
            ST_CLOSE: state_next = rd_en ? ST_LAST : ST_WR;
            ST_LAST:  state_next = ST_WR;
            ST_WR:    state_next = ST_SRD;
            ST_SRD:
            begin
                if (k_reg != cnt_cur)
                begin
                    state_next = ST_SACC;
                end
                else
                begin
                    state_next = (wvol_reg == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_SACC:  state_next = ST_SRD;
            ST_DIV:   state_next = (dcnt_reg == DW'(1)) ? ST_OUT : ST_DIV;
            ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath without reset
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            item_reg <= q_item;
            sym_reg  <= SW'(q_item.symbol_index);
        end
        case (state_reg)
            ST_MUL:
            begin
                upd_sym_reg   <= sym_reg;
                upd_price_reg <= item_reg.trade_price;
                upd_vol_reg   <= item_reg.trade_volume;
                prod_reg      <= ohlc_pkg::PROD_W'(item_reg.trade_price) *
                                 ohlc_pkg::PROD_W'(item_reg.trade_volume);
            end
            ST_CLOSE:
            begin
                candle_reg.open_p  <= open_reg[sym_reg];
                candle_reg.high_p  <= high_reg[sym_reg];
                candle_reg.low_p   <= low_reg[sym_reg];
                candle_reg.close_p <= close_reg[sym_reg];
                candle_reg.vol     <= vol_reg[sym_reg];
                candle_reg.wgt     <= wgt_reg[sym_reg];
                carried_reg        <= rd_en;
            end
            ST_LAST:
            begin
                candle_reg <= rd_reg;
            end
            ST_WR:
            begin
                k_reg    <= '0;
                wsum_reg <= '0;
                wvol_reg <= '0;
            end
            ST_SRD:
            begin
                rem_reg  <= '0;
                quo_reg  <= '0;
                over_reg <= 1'b0;
                dcnt_reg <= DW'(SUM_W);
            end
            ST_SACC:
            begin
                wsum_reg <= wsum_reg + SUM_W'(rd_reg.wgt);
                wvol_reg <= wvol_reg + SVOL_W'(rd_reg.vol);
                k_reg    <= k_reg + CW'(1);
            end
            ST_DIV:
            begin
                wsum_reg <= {wsum_reg[SUM_W-2:0], 1'b0};
                rem_reg  <= r_ge ? (r_shift - {1'b0, wvol_reg}) : r_shift;
                quo_reg  <= {quo_reg[ohlc_pkg::PRICE_W-2:0], r_ge};
                over_reg <= over_reg | quo_reg[ohlc_pkg::PRICE_W-1];
                dcnt_reg <= dcnt_reg - DW'(1);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
        if (out_load)
        begin
            out_item_reg <= out_build;
        end
    end

    // control and per-symbol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SYMBOLS; i++)
            begin
                open_reg[i]  <= '0;
                high_reg[i]  <= '0;
                low_reg[i]   <= '0;
                close_reg[i] <= '0;
                vol_reg[i]   <= '0;
                wgt_reg[i]   <= '0;
                head_reg[i]  <= '0;
                cnt_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!candle_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // trade: open on first trade, track extremes, saturate sums
            if (state_reg == ST_UPD)
            begin
                if (first_trade)
                begin
                    open_reg[upd_sym_reg] <= upd_price_reg;
                end
                if (first_trade || (upd_price_reg > high_reg[upd_sym_reg]))
                begin
                    high_reg[upd_sym_reg] <= upd_price_reg;
                end
                if (first_trade || (upd_price_reg < low_reg[upd_sym_reg]))
                begin
                    low_reg[upd_sym_reg] <= upd_price_reg;
                end
                close_reg[upd_sym_reg] <= upd_price_reg;
                vol_reg[upd_sym_reg]   <= vsum[ohlc_pkg::VOL_W] ?
                                          ohlc_pkg::VOL_MAX : vsum[ohlc_pkg::VOL_W-1:0];
                wgt_reg[upd_sym_reg]   <= wgsum[ohlc_pkg::WGT_W] ?
                                          ohlc_pkg::WGT_MAX : wgsum[ohlc_pkg::WGT_W-1:0];
            end

            // close: advance ring and clear accumulators
            if (state_reg == ST_WR)
            begin
                head_reg[sym_reg] <= (head_cur == HW'(WINDOW_DEPTH - 1)) ?
                                     HW'(0) : head_cur + HW'(1);
                if (cnt_cur < CW'(WINDOW_DEPTH))
                begin
                    cnt_reg[sym_reg] <= cnt_cur + CW'(1);
                end
                open_reg[sym_reg]  <= '0;
                high_reg[sym_reg]  <= '0;
                low_reg[sym_reg]   <= '0;
                close_reg[sym_reg] <= '0;
                vol_reg[sym_reg]   <= '0;
                wgt_reg[sym_reg]   <= '0;
            end
        end
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> wvol_reg != '0)
        else $error("division by zero window volume");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRD |-> (k_reg <= cnt_cur && cnt_cur != '0))
        else $error("window scan out of range");
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result issued outside output step");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SRD |-> cnt_cur <= CW'(WINDOW_DEPTH))
        else $error("window count above depth");

endmodule

// ===== rtl/ohlc_candle_vwap_aggregator.sv =====
// Channel   | Direction | Payload              | Handshake
// request   | in        | req (in_item_t)      | req_valid / req_stall
// candle    | out       | candle (out_item_t)  | candle_valid / candle_stall
//
// In the back end a trade is multiplied, then accumulated.
// A close stores the candle (or repeats the newest one) in the ring memory, then
// reads and accumulates its n window entries one at a time, then runs a one-bit-per-cycle divider.
// Reset is asynchronous, active low; the window ring itself is never cleared.
// A 2-entry queue decouples request intake from execution; a stalled result
// holds in the output register while the back end finishes its next item.
module ohlc_candle_vwap_aggregator #(
    parameter int SYMBOLS      = 4,
    parameter int WINDOW_DEPTH = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ohlc_pkg::in_item_t  req,
    output logic                candle_valid,
    input  logic                candle_stall,
    output ohlc_pkg::out_item_t candle
);

    logic               q_valid;
    logic               q_stall;
    ohlc_pkg::in_item_t q_item;

    ohlc_front #(
        .SYMBOLS (SYMBOLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_item    (q_item)
    );

    ohlc_back #(
        .SYMBOLS      (SYMBOLS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_stall      (q_stall),
        .q_item       (q_item),
        .candle_valid (candle_valid),
        .candle_stall (candle_stall),
        .candle       (candle)
    );

endmodule

// ===== bench/ohlc_candle_vwap_aggregator_tb.sv =====
module ohlc_candle_vwap_aggregator_tb;

    localparam int NSYM     = 4;
    localparam int DEPTH    = 15;
    localparam int WD_LIMIT = 4000;
    localparam int N_RANDOM = 1500;

    // candle and window predictor with a queue of pending candles
    class candle_scoreboard;
        logic [ohlc_pkg::PRICE_W-1:0] open_p  [NSYM];
        logic [ohlc_pkg::PRICE_W-1:0] high_p  [NSYM];
        logic [ohlc_pkg::PRICE_W-1:0] low_p   [NSYM];
        logic [ohlc_pkg::PRICE_W-1:0] close_p [NSYM];
        logic [ohlc_pkg::VOL_W-1:0]   vol_acc [NSYM];
        logic [ohlc_pkg::WGT_W-1:0]   wgt_acc [NSYM];
        ohlc_pkg::candle_t            ring    [NSYM][DEPTH];
        int                           filled  [NSYM];
        int                           head    [NSYM];
        ohlc_pkg::out_item_t          pending_candles[$];
        int                           errors;

        function new();
            for (int s = 0; s < NSYM; s++)
            begin
                open_p[s]  = '0;
                high_p[s]  = '0;
                low_p[s]   = '0;
                close_p[s] = '0;
                vol_acc[s] = '0;
                wgt_acc[s] = '0;
                filled[s]  = 0;
                head[s]    = 0;
            end
            errors = 0;
        endfunction

        function void note_item(ohlc_pkg::in_item_t it);
            int                             s;
            logic [ohlc_pkg::PROD_W-1:0]    prod;
            logic [ohlc_pkg::VOL_W:0]       vsum;
            logic [ohlc_pkg::WGT_W:0]       wsum;
            ohlc_pkg::candle_t              c;
            logic [67:0]                    win_wgt;
            logic [ohlc_pkg::WVOL_W:0]      win_vol;
            logic [67:0]                    quot;
            ohlc_pkg::out_item_t            r;
            s = int'(it.symbol_index);
            if (it.cmd == ohlc_pkg::CMD_TRADE)
            begin
                prod = ohlc_pkg::PROD_W'(it.trade_price) * ohlc_pkg::PROD_W'(it.trade_volume);
                if (vol_acc[s] == '0)
                begin
                    open_p[s] = it.trade_price;
                    high_p[s] = it.trade_price;
                    low_p[s]  = it.trade_price;
                end
                close_p[s] = it.trade_price;
                if (it.trade_price > high_p[s]) high_p[s] = it.trade_price;
                if (it.trade_price < low_p[s])  low_p[s]  = it.trade_price;
                vsum = {1'b0, vol_acc[s]} + (ohlc_pkg::VOL_W + 1)'(it.trade_volume);
                vol_acc[s] = vsum[ohlc_pkg::VOL_W] ?
                             ohlc_pkg::VOL_MAX : vsum[ohlc_pkg::VOL_W-1:0];
                wsum = {1'b0, wgt_acc[s]} + (ohlc_pkg::WGT_W + 1)'(prod);
                wgt_acc[s] = wsum[ohlc_pkg::WGT_W] ?
                             ohlc_pkg::WGT_MAX : wsum[ohlc_pkg::WGT_W-1:0];
                return;
            end
            // close: build the candle, or repeat the newest one when empty
            c = '{open_p[s], high_p[s], low_p[s], close_p[s], vol_acc[s], wgt_acc[s]};
            r.carried_forward = 1'b0;
            if (filled[s] > 0 && vol_acc[s] == '0)
            begin
                c = ring[s][(head[s] + DEPTH - 1) % DEPTH];
                r.carried_forward = 1'b1;
            end
            ring[s][head[s]] = c;
            head[s] = (head[s] + 1) % DEPTH;
            if (filled[s] < DEPTH) filled[s]++;
            win_wgt = '0;
            win_vol = '0;
            for (int k = 0; k < filled[s]; k++)
            begin
                win_wgt += 68'(ring[s][k].wgt);
                win_vol += (ohlc_pkg::WVOL_W + 1)'(ring[s][k].vol);
            end
            quot = (win_vol != '0) ? win_wgt / 68'(win_vol) : '0;
            r.out_symbol    = 2'(s);
            r.candle_open   = c.open_p;
            r.candle_high   = c.high_p;
            r.candle_low    = c.low_p;
            r.candle_close  = c.close_p;
            r.candle_volume = c.vol;
            r.window_vwap   = (quot > 68'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            r.window_volume = win_vol[ohlc_pkg::WVOL_W] ?
                              ohlc_pkg::WVOL_MAX : win_vol[ohlc_pkg::WVOL_W-1:0];
            pending_candles.push_back(r);
            open_p[s]  = '0;
            high_p[s]  = '0;
            low_p[s]   = '0;
            close_p[s] = '0;
            vol_acc[s] = '0;
            wgt_acc[s] = '0;
        endfunction

        function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(ohlc_pkg::out_item_t got);
            ohlc_pkg::out_item_t e;
            if (pending_candles.size() == 0)
            begin
                $error("candle with no pending expectation: %p", got);
                errors++;
                return;
            end
            e = pending_candles.pop_front();
            cmp_field("out_symbol",      64'(e.out_symbol),      64'(got.out_symbol));
            cmp_field("candle_open",     64'(e.candle_open),     64'(got.candle_open));
            cmp_field("candle_high",     64'(e.candle_high),     64'(got.candle_high));
            cmp_field("candle_low",      64'(e.candle_low),      64'(got.candle_low));
            cmp_field("candle_close",    64'(e.candle_close),    64'(got.candle_close));
            cmp_field("candle_volume",   64'(e.candle_volume),   64'(got.candle_volume));
            cmp_field("carried_forward", 64'(e.carried_forward), 64'(got.carried_forward));
            cmp_field("window_vwap",     64'(e.window_vwap),     64'(got.window_vwap));
            cmp_field("window_volume",   64'(e.window_volume),   64'(got.window_volume));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    ohlc_pkg::in_item_t  req;
    logic                candle_valid;
    logic                candle_stall;
    ohlc_pkg::out_item_t candle;

    candle_scoreboard sb;
    int                idle_cycles;

    ohlc_candle_vwap_aggregator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .candle_valid (candle_valid),
        .candle_stall (candle_stall),
        .candle       (candle)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // drive one item; called at a falling edge, returns at a falling edge
    task automatic send_item(logic cmd, int s, logic [31:0] price, logic [23:0] vol);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid          = 1'b1;
        req.cmd            = cmd;
        req.symbol_index   = 2'(s);
        req.trade_price    = price;
        req.trade_volume   = vol;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_item(req);
        @(negedge clk);
    endtask

    task automatic send_trade(int s, logic [31:0] price, logic [23:0] vol);
        send_trade_core: send_item(ohlc_pkg::CMD_TRADE, s, price, vol);
    endtask

    task automatic send_close(int s);
        send_item(ohlc_pkg::CMD_CLOSE, s, $urandom, 24'($urandom));
    endtask

    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1_000_000 + $urandom_range(0, 5000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_volume();
        case ($urandom_range(0, 7))
            0:       return 24'h0;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom_range(1, 100));
            default: return 24'($urandom);
        endcase
    endfunction

    // candle receiver with random stall per item
    initial
    begin
        int n;
        candle_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = $urandom_range(0, 4);
            candle_stall = 1'b1;
            repeat (n) @(negedge clk);
            candle_stall = 1'b0;
            @(posedge clk);
            while (!candle_valid) @(posedge clk);
            sb.check_result(candle);
            @(negedge clk);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (candle_valid && !candle_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int cnt;
        sb           = new();
        idle_cycles  = 0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty minute with no history
        send_close(0);
        // zero-volume trades re-open the candle, no history
        send_trade(1, 32'd500, 24'd0);
        send_trade(1, 32'd700, 24'd0);
        send_close(1);
        // extremes of price and volume
        send_trade(2, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_trade(2, 32'h0, 24'hFF_FFFF);
        send_trade(2, 32'h8000_0000, 24'd1);
        send_close(2);
        // repeated candle, stored twice
        send_close(2);
        send_close(1);
        // full window wraps over the oldest candle
        for (int i = 0; i < 17; i++)
        begin
            send_trade(0, pick_price(), pick_volume());
            send_close(0);
        end
        // weighted sum saturates
        for (int i = 0; i < 200; i++)
            send_trade(3, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_close(3);
        send_close(3);

        // random mix: mostly trades, with randomly placed closes
        cnt = 0;
        while (cnt < N_RANDOM)
        begin
            if ($urandom_range(0, 7) == 0)
                send_close($urandom_range(0, 3));
            else
                send_trade($urandom_range(0, 3), pick_price(), pick_volume());
            cnt++;
        end
        req_valid = 1'b0;

        while (sb.pending_candles.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending_candles.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
